// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, sampled on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent true implies consequent true in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// expression must never be true
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

// File: rtl/ptw4_pkg.sv
// ----------------------------------------------------------------------------
// ptw4_pkg
// shared types, constants and helpers of the four-level page table walker
// ----------------------------------------------------------------------------
package ptw4_pkg;

  // table store geometry
  localparam int STORE_WORDS = 4096;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int WORD_W      = 64;

  // payload widths
  localparam int IDX_IN_W = 12;
  localparam int PA_W     = 52;
  localparam int VA_W     = 48;
  localparam int IN_DW    = 176;
  localparam int OUT_DW   = 56;

  // address arithmetic
  localparam int LVL_IDX_W = 9;
  localparam int OFFSET_W  = 12;
  localparam int SUM_W     = PA_W - 3 + 1;
  localparam int MARK_W    = 11;

  localparam logic [MARK_W-1:0] MARK_ALLOCATED = MARK_W'(1);

  // operation codes carried on in_tuser
  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DONE
  } ptw_state_t;

  typedef struct packed {
    logic       clr_en;
    logic       wr_en;
    logic       start;
    logic       finish;
    logic       fin_found;
    logic       out_load_fin;
    logic       out_load_held;
    logic [1:0] lvl;
  } ptw_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic range_ok;
    logic mark_ok;
    logic out_free;
  } ptw_status_t;

  // index of the next lower level, lvl = levels still to read after this one
  function automatic logic [LVL_IDX_W-1:0] next_index(input logic [VA_W-1:0] va,
                                                      input logic [1:0] lvl);
    logic [LVL_IDX_W-1:0] idx;
    unique case (lvl)
      2'd3:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      2'd1:    idx = va[20:12];
      default: idx = va[47:39];
    endcase
    return idx;
  endfunction

endpackage

// File: rtl/ptw4_ram.sv
// ----------------------------------------------------------------------------
// ptw4_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ptw4_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/ptw4_ctrl.sv
// ----------------------------------------------------------------------------
// ptw4_ctrl
// sequencer: store clearing, write acceptance and the four-level walk
// ----------------------------------------------------------------------------
module ptw4_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tuser,
  input  ptw4_pkg::ptw_status_t status,
  output ptw4_pkg::ptw_cmd_t    cmd
);

  import ptw4_pkg::*;

  ptw_state_t state_r, state_nxt;
  logic [1:0] lvl_r, lvl_nxt;

  logic acc_wr, acc_tr, finish_c, found_c;

  // decode of the current cycle
  always_comb begin
    acc_wr   = 1'b0;
    acc_tr   = 1'b0;
    finish_c = 1'b0;
    found_c  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        acc_wr   = in_tvalid && (in_tuser == OP_WRITE);
        acc_tr   = in_tvalid && (in_tuser == OP_TRANSLATE);
        finish_c = acc_tr && !status.range_ok;
      end
      ST_CHECK: begin
        priority if (!status.mark_ok) begin
          finish_c = 1'b1;
        end else if (lvl_r == 2'd0) begin
          finish_c = 1'b1;
          found_c  = 1'b1;
        end else if (!status.range_ok) begin
          finish_c = 1'b1;
        end else begin
          finish_c = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (finish_c) begin
          state_nxt = status.out_free ? ST_IDLE : ST_DONE;
        end else if (acc_tr) begin
          state_nxt = ST_CHECK;
          lvl_nxt   = 2'd3;
        end
      end
      ST_CHECK: begin
        if (finish_c) begin
          state_nxt = status.out_free ? ST_IDLE : ST_DONE;
        end else begin
          lvl_nxt = lvl_r - 2'd1;
        end
      end
      ST_DONE: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_tready         = (state_r == ST_IDLE);
    cmd               = '0;
    cmd.clr_en        = (state_r == ST_CLEAR);
    cmd.wr_en         = acc_wr;
    cmd.start         = acc_tr;
    cmd.finish        = finish_c;
    cmd.fin_found     = found_c;
    cmd.out_load_fin  = finish_c && status.out_free;
    cmd.out_load_held = (state_r == ST_DONE) && status.out_free;
    cmd.lvl           = lvl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      lvl_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

endmodule

// File: rtl/ptw4_dpath.sv
// ----------------------------------------------------------------------------
// ptw4_dpath
// table store, entry address arithmetic, result and output registers
// ----------------------------------------------------------------------------
module ptw4_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ptw4_pkg::ptw_cmd_t             cmd,
  output ptw4_pkg::ptw_status_t          status,
  input  logic [ptw4_pkg::IN_DW-1:0]     in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ptw4_pkg::OUT_DW-1:0]    out_tdata,
  output logic                           out_tuser
);

  import ptw4_pkg::*;

  logic [IDX_IN_W-1:0] widx_in;
  logic [WORD_W-1:0]   wdata_in;
  logic [PA_W-1:0]     root_in;
  logic [VA_W-1:0]     va_in;

  assign widx_in  = in_tdata[11:0];
  assign wdata_in = in_tdata[75:12];
  assign root_in  = in_tdata[127:76];
  assign va_in    = in_tdata[175:128];

  logic [VA_W-1:0]   va_r;
  logic [ADDR_W-1:0] clr_r;
  logic              res_found_r;
  logic [PA_W-1:0]   res_pa_r;
  logic              out_valid_r;
  logic              out_found_r;
  logic [PA_W-1:0]   out_pa_r;

  logic [WORD_W-1:0]    rd_data;
  logic [PA_W-1:0]      base_c;
  logic [LVL_IDX_W-1:0] idx_c;
  logic [SUM_W-1:0]     sum_c;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic                 wr_in_range;
  logic [PA_W-1:0]      fin_pa;

  // entry word = (table base >> 3) + level index
  always_comb begin
    base_c = cmd.start ? root_in : {rd_data[51:12], OFFSET_W'(0)};
    idx_c  = cmd.start ? va_in[47:39] : next_index(va_r, cmd.lvl);
    sum_c  = SUM_W'(base_c[PA_W-1:3]) + SUM_W'(idx_c);
  end

  assign wr_in_range = 32'(widx_in) < 32'(STORE_WORDS);

  always_comb begin
    ram_we    = cmd.clr_en || (cmd.wr_en && wr_in_range);
    ram_waddr = cmd.clr_en ? clr_r : ADDR_W'(widx_in);
    ram_wdata = cmd.clr_en ? '0 : wdata_in;
  end

  ptw4_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ADDR_W'(sum_c)),
    .rdata (rd_data)
  );

  // frame base low bits are zero, so adding the offset is a concatenation
  assign fin_pa = cmd.fin_found ? {rd_data[51:12], va_r[11:0]} : '0;

  always_comb begin
    status.clr_last = (clr_r == ADDR_W'(STORE_WORDS - 1));
    status.range_ok = sum_c < SUM_W'(STORE_WORDS);
    status.mark_ok  = (rd_data[62:52] == MARK_ALLOCATED);
    status.out_free = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_en) clr_r <= clr_r + ADDR_W'(1);
      if (cmd.out_load_fin || cmd.out_load_held) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) va_r <= va_in;
    if (cmd.finish) begin
      res_found_r <= cmd.fin_found;
      res_pa_r    <= fin_pa;
    end
    if (cmd.out_load_fin) begin
      out_found_r <= cmd.fin_found;
      out_pa_r    <= fin_pa;
    end else if (cmd.out_load_held) begin
      out_found_r <= res_found_r;
      out_pa_r    <= res_pa_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = OUT_DW'(out_pa_r);

endmodule

// File: rtl/page_table_walk_4level_unit.sv
// ----------------------------------------------------------------------------
// page_table_walk_4level_unit
// four-level page table walker over an internal 64-bit table store
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one transaction per item; in_tuser selects write (0) or translate (1)
//   out_* : one transaction per translate, none per write; out_tuser = found
//   a write transaction stores one table word
//   a translate reads the level 4 entry in its accept cycle, then checks one
//   level per cycle as each registered store read returns; the result goes to
//   the output register, or is parked while that is full, and a new item is
//   taken only once the walk is over, so translates never overlap, bound by
//   the four dependent reads through the single store read port
//   an out-of-store table or a bad allocated marker ends the walk early
//   reset: the store is swept to zero, one word a cycle over all STORE_WORDS
//   (4096) words, with in_tready low throughout
//   stall: a held result blocks the next accept until taken; a walk that ends
//   while the output register is still full parks its result until taken
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module page_table_walk_4level_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // slave side
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // word_index[11:0], word_data[75:12], root_address[127:76],
  // lin_addr[175:128]
  input  logic [ptw4_pkg::IN_DW-1:0]     in_tdata,
  // operation[0]
  input  logic                           in_tuser,
  // master side
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // physical_address[51:0], zero padded
  output logic [ptw4_pkg::OUT_DW-1:0]    out_tdata,
  // found[0]
  output logic                           out_tuser
);

  import ptw4_pkg::*;

  ptw_cmd_t    cmd;
  ptw_status_t status;

  // sequencer
  ptw4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .status    (status),
    .cmd       (cmd)
  );

  // store, address math and output register
  ptw4_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // a result is never loaded over one still waiting
  `ASSERT_IMPL(a_no_overwrite, cmd.out_load_fin || cmd.out_load_held, !out_tvalid || out_tready)
  // only one source feeds the output register at a time
  `ASSERT_NEVER(a_one_source, cmd.out_load_fin && cmd.out_load_held)
  // a not-found result carries address zero
  `ASSERT_IMPL(a_miss_zero, out_tvalid && !out_tuser, out_tdata == '0)
  // the clearing sweep never overlaps a table write or the start of a walk
  `ASSERT_NEVER(a_clear_excl, cmd.clr_en && (cmd.wr_en || cmd.start))

endmodule
